// File: rtl/odometry_distance_event_tracker_core_macros.svh
// Assertion macros used by the checker file of the distance event tracker.
// Needs clk and rst_n in the scope of each use.
`ifndef ODOMETRY_DISTANCE_EVENT_TRACKER_CORE_MACROS_SVH
`define ODOMETRY_DISTANCE_EVENT_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ODET_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odet: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define ODET_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odet: next-cycle check failed");

`endif

// File: rtl/odet_pkg.sv
// Shared constants of the distance event tracker: item kinds, register indexes,
// reset values, port widths, wheel divisor and serial iteration counts. No dependencies.
package odet_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] KIND_POSE  = 2'd0;
  localparam logic [1:0] KIND_WHEEL = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_STEP_THRESHOLD = 1'b0;
  localparam logic CFG_YAW_LIMIT      = 1'b1;

  // Register reset values
  localparam logic [31:0] STEP_THRESHOLD_RST = 32'd13107;
  localparam logic [14:0] YAW_LIMIT_RST      = 15'd16384;

  // Port widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - 33;

  // Joint position scale for wheel items
  localparam logic [31:0] WHEEL_DIVISOR = 32'd10;

  // Last iteration indexes of the serial units
  localparam logic [5:0] DIV_LAST  = 6'd31;
  localparam logic [5:0] MUL_LAST  = 6'd33;
  localparam logic [5:0] SQRT_LAST = 6'd31;

endpackage

// File: rtl/odometry_distance_event_tracker_core.sv
// Distance event tracker core: odometry steps, saturating total, event count.
// Depends on odet_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in_     | sink      | in_tvalid / in_tready    | tuser kind, tdata x,y,yaw,set
//  out_    | source    | out_tvalid / out_tready  | tdata distance, event flag
//  cfg_    | sink      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item at a time. A pose item runs setup, the three bit-serial multipliers
// (dx^2, dy^2, event mark), the two-bit-per-cycle square root, then accumulation.
// A wheel item first runs the division by 10, then restores the sign. A set item
// runs the 32-step division by the threshold.
// Synchronous active-low reset clears the state and loads register defaults.
// A stalled result sits in the output register; the next item is accepted
// once the current one has been handed to that register.
module odometry_distance_event_tracker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] pos_x, [63:32] pos_y, [79:64] yaw, [111:80] set_value
  input  logic [odet_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] kind
  input  logic [1:0]                       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] distance, [32] event_res, [39:33] zero
  output logic [odet_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DIV    = 11'b00000000010,
    S_DIVEND = 11'b00000000100,
    S_PREP   = 11'b00000001000,
    S_MUL    = 11'b00000010000,
    S_SUM    = 11'b00000100000,
    S_SQRT   = 11'b00001000000,
    S_ACC    = 11'b00010000000,
    S_COMP   = 11'b00100000000,
    S_CHK    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  // One step of a shift-add multiplier: add the multiplicand to the high half
  // when the low bit of the multiplier is set, then shift right.
  function automatic logic [67:0] mul_step(input logic [67:0] p, input logic [33:0] a);
    logic [34:0] s;
    s = {1'b0, p[67:34]} + (p[0] ? {1'b0, a} : 35'd0);
    return {s, p[33:1]};
  endfunction

  // Registers
  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        comp_r, comp_nxt;
  logic        neg_r, neg_nxt;
  logic        ev_r, ev_nxt;
  logic [31:0] th_r, th_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] set_r, set_nxt;
  logic [31:0] div_d_r, div_d_nxt;
  logic [31:0] div_rem_r, div_rem_nxt;
  logic [31:0] div_v_r, div_v_nxt;
  logic [33:0] ax_r, ax_nxt;
  logic [33:0] ay_r, ay_nxt;
  logic [67:0] px_r, px_nxt;
  logic [67:0] py_r, py_nxt;
  logic [67:0] pm_r, pm_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] total_r, total_nxt;
  logic [33:0] cnt1_r, cnt1_nxt;      // event_count + 1
  logic [31:0] last_x_r, last_x_nxt;
  logic [31:0] last_y_r, last_y_nxt;
  logic        have_pos_r, have_pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_dist_r, out_dist_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic [31:0] thr_cfg_r, thr_cfg_nxt;
  logic [14:0] yaw_lim_r, yaw_lim_nxt;

  // Input fields
  logic [31:0] in_pos_x, in_pos_y, in_set_value;
  logic [15:0] in_yaw;
  logic [1:0]  in_kind;
  logic        in_accept;

  assign in_pos_x     = in_tdata[31:0];
  assign in_pos_y     = in_tdata[63:32];
  assign in_yaw       = in_tdata[79:64];
  assign in_set_value = in_tdata[111:80];
  assign in_kind      = in_tuser;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{odet_pkg::OUT_PAD_W{1'b0}}, out_ev_r, out_dist_r};

  // Datapath pieces
  logic [31:0] thr_eff, in_mag;
  logic [32:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] base_x, base_y, mag_x, mag_y;
  logic [32:0] dx, dy;
  logic [64:0] sq_sum;
  logic [34:0] sq_sh, sq_trial;
  logic        sq_ge;
  logic [32:0] acc_sum, comp_sum;
  logic        ev_hit;

  // A zero threshold acts as one
  assign thr_eff  = (thr_cfg_r == 32'd0) ? 32'd1 : thr_cfg_r;
  assign in_mag   = in_pos_x[31] ? (32'd0 - in_pos_x) : in_pos_x;

  // Restoring division, one quotient bit per cycle
  assign div_t    = {div_rem_r, div_d_r[31]};
  assign div_ge   = (div_t >= {1'b0, div_v_r});
  assign div_diff = div_t - {1'b0, div_v_r};

  // With no known position the step starts at the item's own position
  assign base_x = have_pos_r ? last_x_r : x_r;
  assign base_y = have_pos_r ? last_y_r : y_r;
  assign dx     = {x_r[31], x_r} - {base_x[31], base_x};
  assign dy     = {y_r[31], y_r} - {base_y[31], base_y};
  assign mag_x  = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
  assign mag_y  = dy[32] ? 32'(33'd0 - dy) : dy[31:0];

  assign sq_sum = {1'b0, px_r[63:0]} + {1'b0, py_r[63:0]};

  // Digit-by-digit square root, two radicand bits per cycle
  assign sq_sh    = {rem_r[32:0], rad_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  assign acc_sum  = {1'b0, total_r} + {1'b0, root_r};
  assign comp_sum = {1'b0, total_r} + {1'b0, th_r};

  // Event when the count is at -1, or the total reaches (count + 1) * threshold
  assign ev_hit = (cnt1_r == 34'd0) || ((pm_r[67:32] == 36'd0) && (pm_r[31:0] <= total_r));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    kind_nxt     = kind_r;
    comp_nxt     = comp_r;
    neg_nxt      = neg_r;
    ev_nxt       = ev_r;
    th_nxt       = th_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    set_nxt      = set_r;
    div_d_nxt    = div_d_r;
    div_rem_nxt  = div_rem_r;
    div_v_nxt    = div_v_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    pm_nxt       = pm_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    total_nxt    = total_r;
    cnt1_nxt     = cnt1_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    have_pos_nxt = have_pos_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt = out_dist_r;
    out_ev_nxt   = out_ev_r;
    thr_cfg_nxt  = thr_cfg_r;
    yaw_lim_nxt  = yaw_lim_r;

    // Configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        odet_pkg::CFG_STEP_THRESHOLD: thr_cfg_nxt = cfg_data;
        odet_pkg::CFG_YAW_LIMIT:      yaw_lim_nxt = cfg_data[14:0];
        default: ;
      endcase
    end

    // Drop the result beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          kind_nxt    = in_kind;
          th_nxt      = thr_eff;
          comp_nxt    = ($signed(in_yaw) >= $signed({1'b0, yaw_lim_r}));
          neg_nxt     = in_pos_x[31];
          ev_nxt      = 1'b0;
          x_nxt       = in_pos_x;
          y_nxt       = in_pos_y;
          set_nxt     = in_set_value;
          cnt_nxt     = 6'd0;
          div_rem_nxt = 32'd0;
          case (in_kind)
            odet_pkg::KIND_POSE: begin
              state_nxt = S_PREP;
            end
            odet_pkg::KIND_WHEEL: begin
              div_d_nxt = in_mag;
              div_v_nxt = odet_pkg::WHEEL_DIVISOR;
              state_nxt = S_DIV;
            end
            odet_pkg::KIND_SET: begin
              div_d_nxt = in_set_value;
              div_v_nxt = thr_eff;
              state_nxt = S_DIV;
            end
            default: begin
              // Unused kind: report the current total, change nothing
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DIV: begin
        div_rem_nxt = div_ge ? div_diff[31:0] : div_t[31:0];
        div_d_nxt   = {div_d_r[30:0], div_ge};
        cnt_nxt     = cnt_r + 6'd1;
        if (cnt_r == odet_pkg::DIV_LAST) begin
          state_nxt = S_DIVEND;
        end
      end

      S_DIVEND: begin
        if (kind_r == odet_pkg::KIND_SET) begin
          total_nxt    = set_r;
          have_pos_nxt = 1'b1;
          if (div_d_r != 32'd0) begin
            cnt1_nxt = {2'b00, div_d_r};
          end else begin
            cnt1_nxt = (set_r == 32'd0) ? 34'd0 : 34'd1;
          end
          state_nxt = S_DONE;
        end else begin
          // Wheel: quotient rounded toward zero, y held at zero
          x_nxt     = neg_r ? (32'd0 - div_d_r) : div_d_r;
          y_nxt     = 32'd0;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        ax_nxt       = {2'b00, mag_x};
        ay_nxt       = {2'b00, mag_y};
        px_nxt       = {36'd0, mag_x};
        py_nxt       = {36'd0, mag_y};
        pm_nxt       = {34'd0, cnt1_r};
        last_x_nxt   = x_r;
        last_y_nxt   = y_r;
        have_pos_nxt = 1'b1;
        cnt_nxt      = 6'd0;
        state_nxt    = S_MUL;
      end

      S_MUL: begin
        px_nxt  = mul_step(px_r, ax_r);
        py_nxt  = mul_step(py_r, ay_r);
        pm_nxt  = mul_step(pm_r, {2'b00, th_r});
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == odet_pkg::MUL_LAST) begin
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        cnt_nxt = 6'd0;
        if (sq_sum[64]) begin
          // Sum of squares past 64 bits: saturate the step
          root_nxt  = 32'hFFFF_FFFF;
          state_nxt = S_ACC;
        end else begin
          rad_nxt   = sq_sum[63:0];
          rem_nxt   = 35'd0;
          root_nxt  = 32'd0;
          state_nxt = S_SQRT;
        end
      end

      S_SQRT: begin
        rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_nxt = {root_r[30:0], sq_ge};
        rad_nxt  = {rad_r[61:0], 2'b00};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == odet_pkg::SQRT_LAST) begin
          state_nxt = S_ACC;
        end
      end

      S_ACC: begin
        total_nxt = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        comp_nxt  = comp_r && (kind_r == odet_pkg::KIND_POSE) && (root_r < th_r);
        state_nxt = S_COMP;
      end

      S_COMP: begin
        // Rotation compensation: add one threshold more
        if (comp_r) begin
          total_nxt = comp_sum[32] ? 32'hFFFF_FFFF : comp_sum[31:0];
        end
        state_nxt = S_CHK;
      end

      S_CHK: begin
        ev_nxt = ev_hit;
        if (ev_hit) begin
          cnt1_nxt = cnt1_r + 34'd1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = total_r;
          out_ev_nxt    = ev_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      total_r     <= 32'd0;
      cnt1_r      <= 34'd1;
      last_x_r    <= 32'd0;
      last_y_r    <= 32'd0;
      have_pos_r  <= 1'b0;
      out_valid_r <= 1'b0;
      thr_cfg_r   <= odet_pkg::STEP_THRESHOLD_RST;
      yaw_lim_r   <= odet_pkg::YAW_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      cnt1_r      <= cnt1_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      have_pos_r  <= have_pos_nxt;
      out_valid_r <= out_valid_nxt;
      thr_cfg_r   <= thr_cfg_nxt;
      yaw_lim_r   <= yaw_lim_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    comp_r     <= comp_nxt;
    neg_r      <= neg_nxt;
    ev_r       <= ev_nxt;
    th_r       <= th_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    set_r      <= set_nxt;
    div_d_r    <= div_d_nxt;
    div_rem_r  <= div_rem_nxt;
    div_v_r    <= div_v_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pm_r       <= pm_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_dist_r <= out_dist_nxt;
    out_ev_r   <= out_ev_nxt;
  end

endmodule

// File: rtl/odet_checker.sv
// Port-level checks of the distance event tracker, bound to the top level.
// Depends on odet_pkg and odometry_distance_event_tracker_core_macros.svh.
`include "odometry_distance_event_tracker_core_macros.svh"

module odet_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [odet_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled result beat holds
  `ODET_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ODET_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // One item in flight: no new beat right after one is taken
  `ODET_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // A fresh result only ever follows a busy cycle
  `ODET_ASSERT_IMPL(a_result_after_work, $rose(out_tvalid), $past(!in_tready))

endmodule

bind odometry_distance_event_tracker_core odet_checker u_odet_checker (.*);
